// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the gradient unit RTL.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a combinational condition at every clock edge outside reset.
`define FCCG_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("gradient unit assertion failed");

// Check that a condition implies another one at the same clock edge.
`define FCCG_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gradient unit assertion failed");

`endif

// ===== rtl/core/fccg_pkg.sv =====
// Shared types, constants and helper functions of the four corner gradient unit.
// No dependencies; every module of the block imports this package.
package fccg_pkg;

  localparam int MAX_DIM_DEF = 1024;
  localparam int COORD_W     = 10;
  localparam int SPAN_W      = 10;
  localparam int ORIGIN_W    = 12;
  localparam int SCREEN_W    = 13;
  localparam int COLOR_W     = 24;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int WGT_W       = 8;
  localparam int PROD_W      = 16;
  localparam int NUM_W       = 18;
  localparam int DIV_STAGES  = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [WGT_W-1:0] FULL = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_TL,
    REG_CORNER_TR,
    REG_CORNER_BL,
    REG_CORNER_BR,
    REG_SPAN_X,
    REG_SPAN_Y,
    REG_ORIGIN_X,
    REG_ORIGIN_Y
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] local_x;
    logic [COORD_W-1:0] local_y;
  } in_item_t;

  typedef struct packed {
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
    logic [COLOR_W-1:0]  pixel_color;
  } out_item_t;

  // Partial state of the axis weight dividers
  typedef struct packed {
    logic [NUM_W-1:0]    rem_x;
    logic [NUM_W-1:0]    rem_y;
    logic [WGT_W-1:0]    q_x;
    logic [WGT_W-1:0]    q_y;
    logic [SCREEN_W-1:0] scr_x;
    logic [SCREEN_W-1:0] scr_y;
  } div_item_t;

  typedef struct packed {
    logic [WGT_W-1:0]    w_tl;
    logic [WGT_W-1:0]    w_tr;
    logic [WGT_W-1:0]    w_bl;
    logic [WGT_W-1:0]    w_br;
    logic [SCREEN_W-1:0] scr_x;
    logic [SCREEN_W-1:0] scr_y;
  } weight_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] tl;
    logic [COLOR_W-1:0] tr;
    logic [COLOR_W-1:0] bl;
    logic [COLOR_W-1:0] br;
  } corners_t;

  // Exact x / 255 for x up to 255*255
  function automatic logic [WGT_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {9'd0, x[PROD_W-1:8]} + 17'd1;
    return t[PROD_W-1:8];
  endfunction

endpackage

// ===== rtl/core/fccg_div_step.sv =====
// One pipeline stage of the axis weight dividers: two restoring quotient bits per axis.
// Depends on fccg_pkg.
module fccg_div_step #(
  parameter int STAGE = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  fccg_pkg::div_item_t          in_item,
  input  logic [fccg_pkg::SPAN_W-1:0]  den_x,
  input  logic [fccg_pkg::SPAN_W-1:0]  den_y,
  output logic                         out_v,
  output fccg_pkg::div_item_t          out_item
);
  import fccg_pkg::*;

  logic      v_r;
  div_item_t item_r;
  div_item_t item_nxt;

  // Trial subtract of the shifted divisor, high quotient bit first
  always_comb begin
    logic [NUM_W-1:0] dx;
    logic [NUM_W-1:0] dy;
    logic [2:0]       sh;
    item_nxt = in_item;
    for (int b = 0; b < 2; b++) begin
      sh = 3'(7 - 2 * STAGE - b);
      dx = NUM_W'(den_x) << sh;
      dy = NUM_W'(den_y) << sh;
      if (item_nxt.rem_x >= dx) begin
        item_nxt.rem_x   = item_nxt.rem_x - dx;
        item_nxt.q_x[sh] = 1'b1;
      end
      if (item_nxt.rem_y >= dy) begin
        item_nxt.rem_y   = item_nxt.rem_y - dy;
        item_nxt.q_y[sh] = 1'b1;
      end
    end
  end

  // Advance valid and payload together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_v    = v_r;
  assign out_item = item_r;

endmodule

// ===== rtl/core/fccg_weight.sv =====
// Corner weight stages: complement products, then division by 255 and the remainder weight.
// Depends on fccg_pkg.
module fccg_weight (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  fccg_pkg::div_item_t    in_item,
  input  logic                   zero_x,
  input  logic                   zero_y,
  output logic                   out_v,
  output fccg_pkg::weight_item_t out_item
);
  import fccg_pkg::*;

  logic                v1_r;
  logic [PROD_W-1:0]   p_tl_r, p_tr_r, p_bl_r;
  logic [SCREEN_W-1:0] scr_x_r, scr_y_r;
  logic [WGT_W-1:0]    wx, wy, ix, iy;
  logic                v2_r;
  weight_item_t        item_r;
  weight_item_t        item_nxt;
  logic [WGT_W+1:0]    wsum;

  // Zero span forces the axis weight to zero
  always_comb begin
    wx = zero_x ? '0 : in_item.q_x;
    wy = zero_y ? '0 : in_item.q_y;
    ix = wx ^ FULL;
    iy = wy ^ FULL;
  end

  // Stage A: register the three weight products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_tl_r  <= ix * iy;
      p_tr_r  <= wx * iy;
      p_bl_r  <= ix * wy;
      scr_x_r <= in_item.scr_x;
      scr_y_r <= in_item.scr_y;
    end
  end

  // Stage B: scale to 255 and give the rest to the bottom right corner
  always_comb begin
    item_nxt.w_tl  = div255(p_tl_r);
    item_nxt.w_tr  = div255(p_tr_r);
    item_nxt.w_bl  = div255(p_bl_r);
    wsum           = 10'(item_nxt.w_tl) + 10'(item_nxt.w_tr) + 10'(item_nxt.w_bl);
    item_nxt.w_br  = FULL - wsum[WGT_W-1:0];
    item_nxt.scr_x = scr_x_r;
    item_nxt.scr_y = scr_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_v    = v2_r;
  assign out_item = item_r;

endmodule

// ===== rtl/core/fccg_blend.sv =====
// Color blend stages: weighted channel sums, then division by 255 into the output register.
// Depends on fccg_pkg.
module fccg_blend (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  fccg_pkg::weight_item_t in_item,
  input  fccg_pkg::corners_t     corners,
  output logic                   out_v,
  output fccg_pkg::out_item_t    out_item
);
  import fccg_pkg::*;

  logic                v1_r;
  logic [PROD_W-1:0]   sum_r [NUM_CHAN];
  logic [PROD_W-1:0]   sum_nxt [NUM_CHAN];
  logic [SCREEN_W-1:0] scr_x_r, scr_y_r;
  logic                v2_r;
  out_item_t           item_r;
  out_item_t           item_nxt;

  // Weighted sum per channel; weights add up to 255 so the sum fits 16 bits
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      sum_nxt[ch] = PROD_W'(corners.tl[ch*CHAN_W +: CHAN_W]) * PROD_W'(in_item.w_tl)
                  + PROD_W'(corners.tr[ch*CHAN_W +: CHAN_W]) * PROD_W'(in_item.w_tr)
                  + PROD_W'(corners.bl[ch*CHAN_W +: CHAN_W]) * PROD_W'(in_item.w_bl)
                  + PROD_W'(corners.br[ch*CHAN_W +: CHAN_W]) * PROD_W'(in_item.w_br);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= sum_nxt;
      scr_x_r <= in_item.scr_x;
      scr_y_r <= in_item.scr_y;
    end
  end

  // Scale each channel back to 8 bits
  always_comb begin
    item_nxt.screen_x = scr_x_r;
    item_nxt.screen_y = scr_y_r;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      item_nxt.pixel_color[ch*CHAN_W +: CHAN_W] = div255(sum_r[ch]);
    end
  end

  // Output register: holds the transaction while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_v    = v2_r;
  assign out_item = item_r;

endmodule

// ===== rtl/core/four_corner_color_gradient_unit.sv =====
// Four corner color gradient unit: per pixel a screen position and a bilinear RGB888 blend.
// Top level; depends on fccg_pkg, fccg_div_step, fccg_weight, fccg_blend, assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one pixel's local column and row.
//   Output channel out_valid/out_ready/out_data returns screen_x, screen_y and pixel_color,
//   exactly one result transaction per input transaction, in order.
//   Configuration: cfg_we with cfg_index and cfg_wdata writes one register at a clock edge;
//   write only while no pixel is in flight.
// Pipeline: 9 register stages (1 saturate stage, 4 divider stages at two quotient bits
//   each, 2 corner weight stages, 2 blend stages), passed in that order; the last blend
//   stage is the output register that drives out_valid and out_data.
// Throughput: one pixel per clock unless the output stalls; every stage carries a valid bit
//   and the pipeline holds bubbles as well as items.
// Stall: when out_valid is high and out_ready low, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated. Items keep entering while the output
//   register is empty or being taken.
// Reset: rst_n is synchronous and active low; it empties the pipeline and clears all
//   configuration registers to zero. No clearing pass is needed.
module four_corner_color_gradient_unit #(
  parameter int MAX_DIM = fccg_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fccg_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fccg_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [fccg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fccg_pkg::COLOR_W-1:0]    cfg_wdata
);
  import fccg_pkg::*;

  `include "assert_macros.svh"

  localparam logic [SCREEN_W-1:0] SPAN_LIM = SCREEN_W'(MAX_DIM - 1);

  corners_t              corners_r;
  logic [SPAN_W-1:0]     span_x_r, span_y_r;
  logic [ORIGIN_W-1:0]   origin_x_r, origin_y_r;

  logic                  en;
  logic [SCREEN_W-1:0]   sx_wide, sy_wide;
  logic [SPAN_W-1:0]     sx, sy;
  logic [COORD_W-1:0]    lx, ly;
  div_item_t             s1_nxt;
  logic                  dv [DIV_STAGES+1];
  div_item_t             ditem [DIV_STAGES+1];
  logic                  wv;
  weight_item_t          witem;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corners_r  <= '0;
      span_x_r   <= '0;
      span_y_r   <= '0;
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CORNER_TL: corners_r.tl <= cfg_wdata;
        REG_CORNER_TR: corners_r.tr <= cfg_wdata;
        REG_CORNER_BL: corners_r.bl <= cfg_wdata;
        REG_CORNER_BR: corners_r.br <= cfg_wdata;
        REG_SPAN_X:    span_x_r     <= cfg_wdata[SPAN_W-1:0];
        REG_SPAN_Y:    span_y_r     <= cfg_wdata[SPAN_W-1:0];
        REG_ORIGIN_X:  origin_x_r   <= cfg_wdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y:  origin_y_r   <= cfg_wdata[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: move whenever the output register is free or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: clamp spans, saturate coordinates, form numerators and screen position
  always_comb begin
    sx_wide = (SCREEN_W'(span_x_r) > SPAN_LIM) ? SPAN_LIM : SCREEN_W'(span_x_r);
    sy_wide = (SCREEN_W'(span_y_r) > SPAN_LIM) ? SPAN_LIM : SCREEN_W'(span_y_r);
    sx      = sx_wide[SPAN_W-1:0];
    sy      = sy_wide[SPAN_W-1:0];
    lx      = (in_data.local_x > sx) ? sx : in_data.local_x;
    ly      = (in_data.local_y > sy) ? sy : in_data.local_y;
    s1_nxt.rem_x = (NUM_W'(lx) << 8) - NUM_W'(lx);
    s1_nxt.rem_y = (NUM_W'(ly) << 8) - NUM_W'(ly);
    s1_nxt.q_x   = '0;
    s1_nxt.q_y   = '0;
    s1_nxt.scr_x = SCREEN_W'(origin_x_r) + SCREEN_W'(lx);
    s1_nxt.scr_y = SCREEN_W'(origin_y_r) + SCREEN_W'(ly);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ditem[0] <= s1_nxt;
    end
  end

  // Axis weight dividers: x*255/span, two quotient bits per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    fccg_div_step #(
      .STAGE (g)
    ) u_div_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (dv[g]),
      .in_item  (ditem[g]),
      .den_x    (sx),
      .den_y    (sy),
      .out_v    (dv[g+1]),
      .out_item (ditem[g+1])
    );
  end

  fccg_weight u_weight (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (dv[DIV_STAGES]),
    .in_item  (ditem[DIV_STAGES]),
    .zero_x   (sx == '0),
    .zero_y   (sy == '0),
    .out_v    (wv),
    .out_item (witem)
  );

  fccg_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (wv),
    .in_item  (witem),
    .corners  (corners_r),
    .out_v    (out_valid),
    .out_item (out_data)
  );

  // A result never lies left of or above the rectangle's origin
  `FCCG_ASSERT_IMPLY(a_scr_x_origin, out_valid, out_data.screen_x >= SCREEN_W'(origin_x_r))
  `FCCG_ASSERT_IMPLY(a_scr_y_origin, out_valid, out_data.screen_y >= SCREEN_W'(origin_y_r))
  // The pipeline only stops while a finished result waits on the receiver
  `FCCG_ASSERT_IMPLY(a_stall_cause, !in_ready, out_valid && !out_ready)

endmodule

// ===== test/fccg_pixel_checker.sv =====
// Pixel checker for the four corner color gradient unit: tracks register writes,
// predicts each pixel from the accepted input and compares the returned pixels in order.
// Depends on fccg_pkg for the channel structs and register names.
module fccg_pixel_checker #(
  parameter int MAX_DIM = fccg_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  fccg_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  fccg_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [fccg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fccg_pkg::COLOR_W-1:0]    cfg_wdata,
  output int                              mismatches,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import fccg_pkg::*;

  // Shadow copy of the configuration registers
  logic [COLOR_W-1:0]  corner_tl, corner_tr, corner_bl, corner_br;
  logic [SPAN_W-1:0]   span_x_q, span_y_q;
  logic [ORIGIN_W-1:0] org_x_q, org_y_q;

  // Pixels predicted but not yet returned, oldest first
  out_item_t pixel_queue[$];

  // Compute screen position and blended color of one pixel
  function automatic out_item_t blend_pixel(in_item_t px);
    int unsigned sx, sy, lx, ly, wx, wy, ix, iy;
    int unsigned w_tl, w_tr, w_bl, w_br, sum;
    out_item_t   r;
    sx = (span_x_q > MAX_DIM - 1) ? MAX_DIM - 1 : span_x_q;
    sy = (span_y_q > MAX_DIM - 1) ? MAX_DIM - 1 : span_y_q;
    lx = (px.local_x > sx) ? sx : px.local_x;
    ly = (px.local_y > sy) ? sy : px.local_y;
    // zero span gives zero weight on that axis
    wx = (sx == 0) ? 0 : lx * 255 / sx;
    wy = (sy == 0) ? 0 : ly * 255 / sy;
    ix = 255 - wx;
    iy = 255 - wy;
    w_tl = ix * iy / 255;
    w_tr = wx * iy / 255;
    w_bl = ix * wy / 255;
    w_br = 255 - (w_tl + w_tr + w_bl);
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      sum = corner_tl[8*ch +: 8] * w_tl + corner_tr[8*ch +: 8] * w_tr
          + corner_bl[8*ch +: 8] * w_bl + corner_br[8*ch +: 8] * w_br;
      r.pixel_color[8*ch +: 8] = CHAN_W'(sum / 255);
    end
    r.screen_x = SCREEN_W'(org_x_q + lx);
    r.screen_y = SCREEN_W'(org_y_q + ly);
    return r;
  endfunction

  // Report a bad pixel transaction; only the first ten get printed
  function automatic void flag_pixel(string what, out_item_t exp_px, out_item_t got_px);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: pixel %s: expected x=%0d y=%0d color=%06h, got x=%0d y=%0d color=%06h",
               $realtime, what, exp_px.screen_x, exp_px.screen_y, exp_px.pixel_color,
               got_px.screen_x, got_px.screen_y, got_px.pixel_color);
  endfunction

  always @(posedge clk) begin
    out_item_t exp_px;
    if (!rst_n) begin
      corner_tl = '0;
      corner_tr = '0;
      corner_bl = '0;
      corner_br = '0;
      span_x_q  = '0;
      span_y_q  = '0;
      org_x_q   = '0;
      org_y_q   = '0;
      pixel_queue.delete();
    end else begin
      // compare a returned pixel with the oldest prediction
      if (out_valid && out_ready) begin
        if (pixel_queue.size() == 0) begin
          flag_pixel("with nothing pending", '0, out_data);
        end else begin
          exp_px = pixel_queue.pop_front();
          if (out_data.screen_x !== exp_px.screen_x ||
              out_data.screen_y !== exp_px.screen_y ||
              out_data.pixel_color !== exp_px.pixel_color)
            flag_pixel("mismatch", exp_px, out_data);
        end
      end
      // predict from the registers in force before this edge
      if (in_valid && in_ready)
        pixel_queue.push_back(blend_pixel(in_data));
      // track register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CORNER_TL: corner_tl = cfg_wdata;
          REG_CORNER_TR: corner_tr = cfg_wdata;
          REG_CORNER_BL: corner_bl = cfg_wdata;
          REG_CORNER_BR: corner_br = cfg_wdata;
          REG_SPAN_X:    span_x_q  = cfg_wdata[SPAN_W-1:0];
          REG_SPAN_Y:    span_y_q  = cfg_wdata[SPAN_W-1:0];
          REG_ORIGIN_X:  org_x_q   = cfg_wdata[ORIGIN_W-1:0];
          default:       org_y_q   = cfg_wdata[ORIGIN_W-1:0];
        endcase
      end
    end
    outstanding = pixel_queue.size();
  end

endmodule

// ===== test/tb_four_corner_color_gradient_unit.sv =====
// Top of the gradient unit testbench: clock, reset, register writes and pixel stimulus
// with random gaps and output stalls. Depends on fccg_pkg and fccg_pixel_checker.
module tb_four_corner_color_gradient_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fccg_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_wdata;
  int                   mismatches;
  int                   outstanding;

  // No idling on either side once set
  bit                   calm;
  int unsigned          cur_span_x, cur_span_y;

  four_corner_color_gradient_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fccg_pixel_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: random stall bursts, long ready stretches
  initial begin
    int hold;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 14);
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(1, 30);
      end
      repeat (hold - 1) @(negedge clk);
    end
  end

  // Write one register; starts and ends on a falling edge
  task automatic write_reg(cfg_reg_t idx, logic [COLOR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_config(logic [23:0] tl, logic [23:0] tr, logic [23:0] bl,
                              logic [23:0] br, int unsigned sx, int unsigned sy,
                              int unsigned ox, int unsigned oy);
    write_reg(REG_CORNER_TL, tl);
    write_reg(REG_CORNER_TR, tr);
    write_reg(REG_CORNER_BL, bl);
    write_reg(REG_CORNER_BR, br);
    write_reg(REG_SPAN_X, COLOR_W'(sx));
    write_reg(REG_SPAN_Y, COLOR_W'(sy));
    write_reg(REG_ORIGIN_X, COLOR_W'(ox));
    write_reg(REG_ORIGIN_Y, COLOR_W'(oy));
    cur_span_x = sx;
    cur_span_y = sy;
  endtask

  // Send one pixel transaction; starts and ends on a falling edge, valid held high
  task automatic send_pixel(int unsigned lx, int unsigned ly);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data.local_x <= lx[COORD_W-1:0];
    in_data.local_y <= ly[COORD_W-1:0];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every pixel to return, then let the pipeline settle
  task automatic drain;
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [23:0] pick_color();
    case ($urandom_range(0, 3))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_span();
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return 1;
      2:       return 1023;
      3, 4:    return $urandom_range(2, 63);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  function automatic int unsigned pick_origin();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  initial begin
    int unsigned lx, ly;
    calm       = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    cur_span_x = 0;
    cur_span_y = 0;

    // Hold reset, then release it on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Pixels straight out of reset: all zero registers
    send_pixel(1023, 1023);
    send_pixel(0, 0);
    drain();

    // Distinct corners on a small rectangle: corners, interior, coordinates past the span
    apply_config(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 7, 5, 100, 200);
    send_pixel(0, 0);
    send_pixel(7, 0);
    send_pixel(0, 5);
    send_pixel(7, 5);
    send_pixel(3, 2);
    send_pixel(8, 6);
    send_pixel(1023, 0);
    send_pixel(1023, 1023);
    drain();

    // Zero span on both axes at the far origin
    apply_config(24'h123456, 24'hABCDEF, 24'hFEDCBA, 24'h654321, 0, 0, 4095, 4095);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(5, 0);
    drain();

    // Widest spans, largest screen position
    apply_config(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 1023, 1023, 4095, 4095);
    send_pixel(1023, 1023);
    send_pixel(0, 1023);
    send_pixel(1023, 0);
    send_pixel(512, 511);
    send_pixel(1, 1);
    send_pixel(682, 341);
    drain();

    // Random settings, mostly in-span coordinates; the last phases run without idling
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 0)
        apply_config(pick_color(), pick_color(), pick_color(), pick_color(),
                     1023, 1023, pick_origin(), pick_origin());
      else
        apply_config(pick_color(), pick_color(), pick_color(), pick_color(),
                     pick_span(), pick_span(), pick_origin(), pick_origin());
      if (phase >= 7)
        calm = 1'b1;
      repeat (100) begin
        lx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                         : $urandom_range(0, cur_span_x);
        ly = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                         : $urandom_range(0, cur_span_y);
        send_pixel(lx, ly);
      end
      drain();
    end

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== four_corner_color_gradient_unit.f =====
+incdir+rtl/core
rtl/core/fccg_pkg.sv
rtl/core/fccg_div_step.sv
rtl/core/fccg_weight.sv
rtl/core/fccg_blend.sv
rtl/core/four_corner_color_gradient_unit.sv
test/fccg_pixel_checker.sv
test/tb_four_corner_color_gradient_unit.sv
